[rtl/core/fldr_pkg.sv]
// Shared types and constants for the fill-light dimmer ramp.
// Used by the step logic, the top level and the port checker; no dependencies.
package fldr_pkg;

	typedef struct packed {
		logic [15:0] light_reading;
		logic [31:0] now_seconds;
		logic        restart_timer;
		logic [3:0]  white_ticks;
		logic [3:0]  red_ticks;
	} item_t;

	typedef struct packed {
		logic [9:0] white_compare;
		logic [9:0] red_compare;
		logic       lamp_on;
		logic [6:0] target_level;
	} result_t;

	typedef struct packed {
		logic        auto_dimming;
		logic        shade_habit;
		logic        auto_switching;
		logic [1:0]  timer_choice;
		logic [1:0]  colour_mode;
		logic [6:0]  manual_brightness;
		logic [15:0] dark_threshold;
		logic        switch_setting;
	} cfg_t;

	typedef struct packed {
		logic        on_state;
		logic [31:0] off_deadline;
		logic        timer_pending;
		logic [6:0]  white_level;
		logic [6:0]  red_level;
		logic [4:0]  white_delay;
		logic [4:0]  red_delay;
	} state_t;

	typedef enum logic [2:0] {
		REG_AUTO_DIMMING      = 3'd0,
		REG_SHADE_HABIT       = 3'd1,
		REG_AUTO_SWITCHING    = 3'd2,
		REG_TIMER_CHOICE      = 3'd3,
		REG_COLOUR_MODE       = 3'd4,
		REG_MANUAL_BRIGHTNESS = 3'd5,
		REG_DARK_THRESHOLD    = 3'd6,
		REG_SWITCH_SETTING    = 3'd7
	} reg_index_t;

	typedef enum logic [1:0] {
		COLOUR_WHITE = 2'd0,
		COLOUR_MIX   = 2'd1,
		COLOUR_RED   = 2'd2
	} colour_t;

	typedef enum logic [1:0] {
		TIMER_NONE = 2'd0,
		TIMER_8H   = 2'd1,
		TIMER_12H  = 2'd2,
		TIMER_16H  = 2'd3
	} timer_t;

	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [31:0] SPAN_8H        = 32'd28800;
	localparam logic [31:0] SPAN_12H       = 32'd43200;
	localparam logic [31:0] SPAN_16H       = 32'd57600;
	localparam logic [31:0] DEADLINE_RESET = 32'd1000;

	localparam logic [6:0] BRIGHT_MAX     = 7'd100;
	localparam logic [6:0] BRIGHT_RESET   = 7'd100;
	localparam logic [9:0] COMPARE_MAX    = 10'd999;
	localparam logic [4:0] DELAY_MAX      = 5'd31;

	// Sun curve: floor((5000 - lux) / 50) by reciprocal 5243 / 2^18.
	localparam logic [15:0] SUN_KNEE   = 16'd5000;
	localparam logic [12:0] SUN_RECIP  = 13'd5243;
	localparam int unsigned SUN_SHIFT  = 18;
	// Shade curve: floor((1000 - lux) / 10) by reciprocal 1639 / 2^14.
	localparam logic [15:0] SHADE_KNEE  = 16'd1000;
	localparam logic [10:0] SHADE_RECIP = 11'd1639;
	localparam int unsigned SHADE_SHIFT = 14;

endpackage

[rtl/core/fldr_step.sv]
// Combinational work for one beat: brightness choice, channel split, ramps,
// PWM compares and the on/off and deadline rules. Depends on fldr_pkg.
module fldr_step #(
	parameter int unsigned RAMP_DELAY = 5
) (
	input  fldr_pkg::cfg_t    cfg,
	input  fldr_pkg::state_t  state,
	input  fldr_pkg::item_t   item,
	output fldr_pkg::state_t  next_state,
	output fldr_pkg::result_t result
);
	import fldr_pkg::*;

	localparam logic [4:0] RAMP_LIMIT = 5'(RAMP_DELAY);

	function automatic logic [6:0] ramp_step(logic [6:0] level, logic [6:0] target);
		logic [6:0] r;
		r = level;
		if (target > level) begin
			r = level + 7'd1;
		end else if (target < level) begin
			r = level - 7'd1;
		end
		return r;
	endfunction

	// floor(level * 999 / 100) = 10 * level - ceil(level / 100).
	function automatic logic [9:0] pwm_compare(logic [6:0] level);
		logic [10:0] tens;
		logic [10:0] adj;
		tens = (11'(level) << 3) + (11'(level) << 1);
		if (level == 7'd0) begin
			adj = 11'd0;
		end else if (level > BRIGHT_MAX) begin
			adj = 11'd2;
		end else begin
			adj = 11'd1;
		end
		return 10'(tens - adj);
	endfunction

	logic [15:0] lux;
	logic [12:0] sun_diff;
	logic [25:0] sun_prod;
	logic [9:0]  shade_diff;
	logic [20:0] shade_prod;
	logic [6:0]  auto_bright;
	logic [6:0]  bright;
	logic [6:0]  gated;
	logic [6:0]  white_target;
	logic [6:0]  red_target;
	logic [5:0]  white_sum;
	logic [5:0]  red_sum;
	logic [4:0]  white_sat;
	logic [4:0]  red_sat;
	logic        on_switch;
	logic        pending;
	logic        rearm;
	logic [31:0] span;

	assign lux = item.light_reading;

	always_comb begin
		sun_diff   = (lux < SUN_KNEE) ? 13'(SUN_KNEE - lux) : 13'd0;
		shade_diff = (lux < SHADE_KNEE) ? 10'(SHADE_KNEE - lux) : 10'd0;
		sun_prod   = 26'(sun_diff) * 26'(SUN_RECIP);
		shade_prod = 21'(shade_diff) * 21'(SHADE_RECIP);
		auto_bright = cfg.shade_habit ? shade_prod[SHADE_SHIFT +: 7]
		                              : sun_prod[SUN_SHIFT +: 7];
		if (cfg.auto_dimming) begin
			bright = auto_bright;
		end else if (cfg.manual_brightness > BRIGHT_MAX) begin
			bright = BRIGHT_MAX;
		end else begin
			bright = cfg.manual_brightness;
		end
		gated = state.on_state ? bright : 7'd0;
	end

	always_comb begin
		case (cfg.colour_mode)
			COLOUR_WHITE: begin
				white_target = gated;
				red_target   = 7'd0;
			end
			COLOUR_MIX: begin
				white_target = gated >> 1;
				red_target   = gated >> 1;
			end
			COLOUR_RED: begin
				white_target = 7'd0;
				red_target   = gated;
			end
			default: begin
				white_target = 7'd0;
				red_target   = 7'd0;
			end
		endcase
	end

	always_comb begin
		case (cfg.timer_choice)
			TIMER_8H:  span = SPAN_8H;
			TIMER_12H: span = SPAN_12H;
			TIMER_16H: span = SPAN_16H;
			default:   span = 32'd0;
		endcase
	end

	always_comb begin
		next_state = state;

		white_sum = 6'(state.white_delay) + 6'(item.white_ticks);
		white_sat = (white_sum > 6'(DELAY_MAX)) ? DELAY_MAX : white_sum[4:0];
		if (white_sat > RAMP_LIMIT) begin
			next_state.white_level = ramp_step(state.white_level, white_target);
			next_state.white_delay = 5'd0;
		end else begin
			next_state.white_delay = white_sat;
		end

		red_sum = 6'(state.red_delay) + 6'(item.red_ticks);
		red_sat = (red_sum > 6'(DELAY_MAX)) ? DELAY_MAX : red_sum[4:0];
		if (red_sat > RAMP_LIMIT) begin
			next_state.red_level = ramp_step(state.red_level, red_target);
			next_state.red_delay = 5'd0;
		end else begin
			next_state.red_delay = red_sat;
		end

		on_switch = cfg.auto_switching ? (lux <= cfg.dark_threshold) : state.on_state;

		// A freshly armed deadline is never equal to the current time.
		pending = state.timer_pending | item.restart_timer;
		rearm   = pending && (cfg.timer_choice != TIMER_NONE);
		next_state.timer_pending = pending & ~rearm;
		if (rearm) begin
			next_state.off_deadline = item.now_seconds + span;
			next_state.on_state     = on_switch;
		end else begin
			next_state.on_state = (state.off_deadline == item.now_seconds) ? 1'b0
			                                                                : on_switch;
		end

		result.white_compare = pwm_compare(next_state.white_level);
		result.red_compare   = pwm_compare(next_state.red_level);
		result.lamp_on       = next_state.on_state;
		result.target_level  = bright;
	end

endmodule

[rtl/core/fill_light_dimmer_ramp.sv]
// Fill-light dimmer: ramped white and red PWM compares from light readings.
// Top level with input register, result register and configuration; uses
// fldr_pkg and fldr_step.
//
// The block takes one beat per clock cycle while in_stall is low and returns exactly
// one result beat for each. An accepted beat waits in the input register until the result
// register can take it; its result is then captured there and offered, with all the work
// of a beat done in a single pass between the two registers. The input side keeps
// accepting while a finished result waits, and stalls only when both the input register
// and the result register are full. The user must make configuration writes only while
// no beat is in flight; the block does not enforce this. A write to switch_setting also
// sets the lamp state. In automatic dimming the computed brightness is written back into
// manual_brightness.
module fill_light_dimmer_ramp #(
	parameter int unsigned RAMP_DELAY = 5
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  fldr_pkg::item_t                      in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output fldr_pkg::result_t                    out_data,
	input  logic                                 cfg_we,
	input  fldr_pkg::reg_index_t                 cfg_index,
	input  logic [fldr_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import fldr_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  next_state;
	item_t   item_s1;
	logic    valid_s1;
	result_t step_result;
	result_t result_q;
	logic    out_valid_q;
	logic    advance;

	assign advance   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = result_q;

	fldr_step #(
		.RAMP_DELAY(RAMP_DELAY)
	) u_step (
		.cfg        (cfg_q),
		.state      (state_q),
		.item       (item_s1),
		.next_state (next_state),
		.result     (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			result_q <= step_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_dimming      <= 1'b0;
			cfg_q.shade_habit       <= 1'b0;
			cfg_q.auto_switching    <= 1'b0;
			cfg_q.timer_choice      <= TIMER_NONE;
			cfg_q.colour_mode       <= COLOUR_WHITE;
			cfg_q.manual_brightness <= BRIGHT_RESET;
			cfg_q.dark_threshold    <= 16'd0;
			cfg_q.switch_setting    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AUTO_DIMMING:      cfg_q.auto_dimming      <= cfg_data[0];
				REG_SHADE_HABIT:       cfg_q.shade_habit       <= cfg_data[0];
				REG_AUTO_SWITCHING:    cfg_q.auto_switching    <= cfg_data[0];
				REG_TIMER_CHOICE:      cfg_q.timer_choice      <= cfg_data[1:0];
				REG_COLOUR_MODE:       cfg_q.colour_mode       <= cfg_data[1:0];
				REG_MANUAL_BRIGHTNESS: cfg_q.manual_brightness <= cfg_data[6:0];
				REG_DARK_THRESHOLD:    cfg_q.dark_threshold    <= cfg_data[15:0];
				REG_SWITCH_SETTING:    cfg_q.switch_setting    <= cfg_data[0];
				default: ;
			endcase
		end else if (advance && cfg_q.auto_dimming) begin
			cfg_q.manual_brightness <= step_result.target_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.on_state      <= 1'b1;
			state_q.off_deadline  <= DEADLINE_RESET;
			state_q.timer_pending <= 1'b0;
			state_q.white_level   <= 7'd0;
			state_q.red_level     <= 7'd0;
			state_q.white_delay   <= 5'd0;
			state_q.red_delay     <= 5'd0;
		end else if (cfg_we && (cfg_index == REG_SWITCH_SETTING)) begin
			state_q.on_state <= cfg_data[0];
		end else if (advance) begin
			state_q <= next_state;
		end
	end

endmodule

[rtl/core/fldr_checker.sv]
// Port-level checks for fill_light_dimmer_ramp, attached by a bind statement.
// Depends on fldr_pkg.
module fldr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input fldr_pkg::result_t out_data
);
	import fldr_pkg::*;

	// A stalled result beat stays valid and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	// Compares and brightness never leave their ranges.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.white_compare <= COMPARE_MAX)
		           && (out_data.red_compare <= COMPARE_MAX)
		           && (out_data.target_level <= BRIGHT_MAX))
		else $error("result field out of range");

	// With the result register empty the input side never stalls.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while result register empty");

endmodule

bind fill_light_dimmer_ramp fldr_checker u_fldr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
